@@ hw/rtl/sse_pkg.sv @@
package sse_pkg;

   // Longest event name kept for dispatch
   localparam int NAME_BYTES = 16;
   localparam int NAME_LEN_W = $clog2(NAME_BYTES + 1);
   localparam int NAME_IDX_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

   // Line phases
   localparam logic [2:0] PH_START   = 3'd0;
   localparam logic [2:0] PH_FIELD   = 3'd1;
   localparam logic [2:0] PH_NOMATCH = 3'd2;
   localparam logic [2:0] PH_DATA    = 3'd3;
   localparam logic [2:0] PH_EVENT   = 3'd4;
   localparam logic [2:0] PH_SKIP    = 3'd5;
   localparam logic [2:0] PH_COMMENT = 3'd6;

   // Result kinds
   localparam logic [2:0] K_DATA  = 3'd0;
   localparam logic [2:0] K_NAME  = 3'd1;
   localparam logic [2:0] K_END   = 3'd2;
   localparam logic [2:0] K_ERROR = 3'd3;
   localparam logic [2:0] K_DONE  = 3'd4;

   // Error codes
   localparam logic [1:0] E_COLON    = 2'd0;
   localparam logic [1:0] E_FIELD    = 2'd1;
   localparam logic [1:0] E_UNTERM   = 2'd2;
   localparam logic [1:0] E_OVERFLOW = 2'd3;

   // Input commands
   localparam logic CMD_BYTE   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // Datapath operations
   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_TAKE_CR = 3'd1;
   localparam logic [2:0] OP_TAKE_B  = 3'd2;
   localparam logic [2:0] OP_ENDLINE = 3'd3;
   localparam logic [2:0] OP_FINISH  = 3'd4;
   localparam logic [2:0] OP_DISP    = 3'd5;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_R     = 8'h72;

   // Start offsets of the field words in FIELD_CHARS
   localparam logic [3:0] FM_EVENT = 4'd0;
   localparam logic [3:0] FM_DATA  = 4'd5;
   localparam logic [3:0] FM_ID    = 4'd9;
   localparam logic [3:0] FM_RETRY = 4'd11;
   // Last letter of event and of data
   localparam logic [3:0] FM_EVENT_END = 4'd4;
   localparam logic [3:0] FM_DATA_END  = 4'd8;

   // "eventdataidretry"
   localparam logic [7:0] FIELD_CHARS [16] = '{
      8'h65, 8'h76, 8'h65, 8'h6E, 8'h74, 8'h64, 8'h61, 8'h74,
      8'h61, 8'h69, 8'h64, 8'h72, 8'h65, 8'h74, 8'h72, 8'h79
   };
   // Bit i set where letter i ends a field word
   localparam logic [15:0] WORD_END = 16'b1000_0101_0001_0000;

   typedef struct packed {
      logic       command;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_byte;
      logic [1:0] error_code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       go;
      logic       accept;
      logic       use_req;
      logic [2:0] op;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic out_ready;
      logic cr_held;
      logic disp_cont;
   } status_type;

endpackage

@@ hw/rtl/sse_ctrl.sv @@
module sse_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sse_pkg::req_type    req_data,
   input  sse_pkg::status_type status,
   output sse_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SECOND = 2'd1;
   localparam logic [1:0] S_DISP   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [2:0] second_ff, second_in;
   logic [2:0] first_op, second_op;
   logic       is_lf, is_cr;

   always_comb begin
      is_lf = req_data.command == sse_pkg::CMD_BYTE && req_data.byte_value == sse_pkg::CHAR_LF;
      is_cr = req_data.command == sse_pkg::CMD_BYTE && req_data.byte_value == sse_pkg::CHAR_CR;

      // A held CR is dropped before LF, else taken as a line byte first
      if (req_data.command == sse_pkg::CMD_FINISH) begin
         second_op = sse_pkg::OP_FINISH;
      end else if (is_cr) begin
         second_op = sse_pkg::OP_NONE;
      end else begin
         second_op = sse_pkg::OP_TAKE_B;
      end

      if (is_lf) begin
         first_op = sse_pkg::OP_ENDLINE;
      end else if (status.cr_held) begin
         first_op = sse_pkg::OP_TAKE_CR;
      end else begin
         first_op = second_op;
      end
   end

   always_comb begin
      state_in    = state_ff;
      second_in   = second_ff;
      req_stall   = 1'b1;
      cmd.go      = 1'b0;
      cmd.accept  = 1'b0;
      cmd.use_req = 1'b0;
      cmd.op      = sse_pkg::OP_NONE;
      cmd.last    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = !status.out_ready;
            if (req_valid && status.out_ready) begin
               cmd.go      = 1'b1;
               cmd.accept  = 1'b1;
               cmd.use_req = 1'b1;
               cmd.op      = first_op;
               cmd.last    = (first_op == sse_pkg::OP_TAKE_CR) ?
                             (second_op == sse_pkg::OP_NONE) : 1'b1;
               second_in   = second_op;
               if (first_op == sse_pkg::OP_TAKE_CR && second_op != sse_pkg::OP_NONE) begin
                  state_in = S_SECOND;
               end else if (status.disp_cont) begin
                  state_in = S_DISP;
               end
            end
         end
         S_SECOND: begin
            if (status.out_ready) begin
               cmd.go   = 1'b1;
               cmd.op   = second_ff;
               state_in = S_IDLE;
            end
         end
         S_DISP: begin
            if (status.out_ready) begin
               cmd.go = 1'b1;
               cmd.op = sse_pkg::OP_DISP;
               if (!status.disp_cont) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         second_ff <= sse_pkg::OP_NONE;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

endmodule

@@ hw/rtl/sse_dpath.sv @@
module sse_dpath (
   input  logic                clock,
   input  logic                reset,
   input  sse_pkg::req_type    req_data,
   input  sse_pkg::cmd_type    cmd,
   output sse_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sse_pkg::rsp_type    rsp_data
);

   logic [2:0]                      phase_ff, phase_in;
   logic [3:0]                      match_ff, match_in;
   logic                            fvb_ff, fvb_in;
   logic                            cr_ff, cr_in;
   logic                            nlp_ff, nlp_in;
   logic                            seen_ff, seen_in;
   logic                            halt_ff, halt_in;
   logic [sse_pkg::NAME_LEN_W-1:0]  len_ff, len_in;
   logic [sse_pkg::NAME_LEN_W-1:0]  idx_ff, idx_in;
   logic [7:0]                      byte_ff;
   logic [7:0]                      name_mem [sse_pkg::NAME_BYTES];
   logic                            rsp_valid_ff, rsp_valid_in;
   sse_pkg::rsp_type                rsp_ff;

   logic [7:0]       tb;
   logic             mem_we;
   logic             disp_go;
   logic             emit;
   sse_pkg::rsp_type emit_data;
   logic             out_ready;

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cmd.op == sse_pkg::OP_TAKE_CR) begin
         tb = sse_pkg::CHAR_CR;
      end else if (cmd.use_req) begin
         tb = req_data.byte_value;
      end else begin
         tb = byte_ff;
      end
   end

   always_comb begin
      phase_in             = phase_ff;
      match_in             = match_ff;
      fvb_in               = fvb_ff;
      cr_in                = cr_ff;
      nlp_in               = nlp_ff;
      seen_in              = seen_ff;
      halt_in              = halt_ff;
      len_in               = len_ff;
      idx_in               = idx_ff;
      mem_we               = 1'b0;
      disp_go              = 1'b0;
      emit                 = 1'b0;
      emit_data.kind       = sse_pkg::K_DATA;
      emit_data.out_byte   = '0;
      emit_data.error_code = sse_pkg::E_COLON;
      emit_data.last       = cmd.last;

      if (cmd.accept && !halt_ff) begin
         cr_in = req_data.command == sse_pkg::CMD_BYTE &&
                 req_data.byte_value == sse_pkg::CHAR_CR;
      end

      if (cmd.go && !halt_ff) begin
         case (cmd.op)
            sse_pkg::OP_TAKE_CR, sse_pkg::OP_TAKE_B: begin
               case (phase_ff)
                  sse_pkg::PH_START: begin
                     phase_in = sse_pkg::PH_FIELD;
                     if (tb == sse_pkg::CHAR_COLON) begin
                        phase_in = sse_pkg::PH_COMMENT;
                     end else if (tb == sse_pkg::CHAR_E) begin
                        match_in = sse_pkg::FM_EVENT;
                     end else if (tb == sse_pkg::CHAR_D) begin
                        match_in = sse_pkg::FM_DATA;
                     end else if (tb == sse_pkg::CHAR_I) begin
                        match_in = sse_pkg::FM_ID;
                     end else if (tb == sse_pkg::CHAR_R) begin
                        match_in = sse_pkg::FM_RETRY;
                     end else begin
                        phase_in = sse_pkg::PH_NOMATCH;
                     end
                  end
                  sse_pkg::PH_FIELD: begin
                     if (tb == sse_pkg::CHAR_COLON) begin
                        if (!sse_pkg::WORD_END[match_ff]) begin
                           emit                 = 1'b1;
                           emit_data.kind       = sse_pkg::K_ERROR;
                           emit_data.error_code = sse_pkg::E_FIELD;
                           emit_data.last       = 1'b1;
                           halt_in              = 1'b1;
                        end else begin
                           fvb_in = 1'b1;
                           if (match_ff == sse_pkg::FM_EVENT_END) begin
                              len_in   = '0;
                              phase_in = sse_pkg::PH_EVENT;
                           end else if (match_ff == sse_pkg::FM_DATA_END) begin
                              // Separate data lines of one event by a newline
                              if (nlp_ff) begin
                                 emit               = 1'b1;
                                 emit_data.out_byte = sse_pkg::CHAR_LF;
                              end
                              nlp_in   = 1'b0;
                              seen_in  = 1'b1;
                              phase_in = sse_pkg::PH_DATA;
                           end else begin
                              phase_in = sse_pkg::PH_SKIP;
                           end
                        end
                     end else if (!sse_pkg::WORD_END[match_ff] &&
                                  sse_pkg::FIELD_CHARS[match_ff + 4'd1] == tb) begin
                        match_in = match_ff + 4'd1;
                     end else begin
                        phase_in = sse_pkg::PH_NOMATCH;
                     end
                  end
                  sse_pkg::PH_NOMATCH: begin
                     if (tb == sse_pkg::CHAR_COLON) begin
                        emit                 = 1'b1;
                        emit_data.kind       = sse_pkg::K_ERROR;
                        emit_data.error_code = sse_pkg::E_FIELD;
                        emit_data.last       = 1'b1;
                        halt_in              = 1'b1;
                     end
                  end
                  sse_pkg::PH_DATA, sse_pkg::PH_EVENT: begin
                     fvb_in = 1'b0;
                     // Drop one space right after the colon
                     if (!(fvb_ff && tb == sse_pkg::CHAR_SPACE)) begin
                        if (phase_ff == sse_pkg::PH_DATA) begin
                           emit               = 1'b1;
                           emit_data.out_byte = tb;
                        end else if (len_ff >= sse_pkg::NAME_LEN_W'(sse_pkg::NAME_BYTES)) begin
                           emit                 = 1'b1;
                           emit_data.kind       = sse_pkg::K_ERROR;
                           emit_data.error_code = sse_pkg::E_OVERFLOW;
                           emit_data.last       = 1'b1;
                           halt_in              = 1'b1;
                        end else begin
                           mem_we = 1'b1;
                           len_in = len_ff + 1'b1;
                        end
                     end
                  end
                  default: begin
                     fvb_in = 1'b0;
                  end
               endcase
            end
            sse_pkg::OP_ENDLINE, sse_pkg::OP_FINISH: begin
               if (phase_ff == sse_pkg::PH_FIELD || phase_ff == sse_pkg::PH_NOMATCH) begin
                  emit                 = 1'b1;
                  emit_data.kind       = sse_pkg::K_ERROR;
                  emit_data.error_code = sse_pkg::E_COLON;
                  emit_data.last       = 1'b1;
                  halt_in              = 1'b1;
               end else begin
                  if (phase_ff == sse_pkg::PH_DATA) begin
                     nlp_in = 1'b1;
                  end
                  phase_in = sse_pkg::PH_START;
                  match_in = '0;
                  fvb_in   = 1'b0;
                  if (cmd.op == sse_pkg::OP_FINISH) begin
                     emit           = 1'b1;
                     emit_data.last = 1'b1;
                     if (seen_ff || len_ff != '0) begin
                        emit_data.kind       = sse_pkg::K_ERROR;
                        emit_data.error_code = sse_pkg::E_UNTERM;
                        halt_in              = 1'b1;
                     end else begin
                        emit_data.kind = sse_pkg::K_DONE;
                     end
                  end else if (phase_ff == sse_pkg::PH_START) begin
                     // Blank line: dispatch a pending event
                     disp_go = seen_ff || len_ff != '0;
                  end
               end
            end
            sse_pkg::OP_DISP: begin
               disp_go = 1'b1;
            end
            default: begin
            end
         endcase

         if (disp_go) begin
            emit = 1'b1;
            if (idx_ff < len_ff) begin
               emit_data.kind     = sse_pkg::K_NAME;
               emit_data.out_byte = name_mem[idx_ff[sse_pkg::NAME_IDX_W-1:0]];
               emit_data.last     = 1'b0;
               idx_in             = idx_ff + 1'b1;
            end else begin
               emit_data.kind = sse_pkg::K_END;
               emit_data.last = 1'b1;
               seen_in        = 1'b0;
               nlp_in         = 1'b0;
               len_in         = '0;
               idx_in         = '0;
            end
         end
      end
   end

   assign rsp_valid_in     = emit || (rsp_valid_ff && rsp_stall);
   assign status.out_ready = out_ready;
   assign status.cr_held   = cr_ff;
   assign status.disp_cont = disp_go && (idx_ff < len_ff);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sse_pkg::PH_START;
         match_ff     <= '0;
         fvb_ff       <= 1'b0;
         cr_ff        <= 1'b0;
         nlp_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         halt_ff      <= 1'b0;
         len_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         match_ff     <= match_in;
         fvb_ff       <= fvb_in;
         cr_ff        <= cr_in;
         nlp_ff       <= nlp_in;
         seen_ff      <= seen_in;
         halt_ff      <= halt_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff <= req_data.byte_value;
      end
      if (emit) begin
         rsp_ff <= emit_data;
      end
      if (mem_we) begin
         name_mem[len_ff[sse_pkg::NAME_IDX_W-1:0]] <= tb;
      end
   end

endmodule

@@ hw/rtl/sse_event_stream_parser.sv @@
// Each result is registered in the single output register before it appears on rsp.
// Throughput: one item per cycle while the output is not stalled; a held CR followed by a
// finish or by a byte other than LF and CR is handled as the CR and then the item, and a
// blank-line dispatch sends each stored name byte and then the end result; no new item is
// taken until either is through. The single output register sets the pace: a stalled result holds the next step.
// Reset (synchronous, active high) clears the line state, the name length and the halt
// flag; the stored name bytes are not cleared.
module sse_event_stream_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sse_pkg::rsp_type rsp_data
);

   sse_pkg::cmd_type    cmd;
   sse_pkg::status_type status;

   sse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .status    (status),
      .cmd       (cmd)
   );

   sse_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hw/rtl/sse_checker.sv @@
module sse_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sse_pkg::rsp_type rsp_data
);

   // Hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != sse_pkg::K_DATA && rsp_data.kind != sse_pkg::K_NAME
      |-> rsp_data.out_byte == 8'd0)
      else $error("byte set on a result without a byte");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != sse_pkg::K_ERROR |-> rsp_data.error_code == 2'd0)
      else $error("error code set on a non-error result");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == sse_pkg::K_ERROR |-> rsp_data.last)
      else $error("error is not the final result of its item");

   // After an error is taken the block stays silent
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.kind == sse_pkg::K_ERROR |=> !rsp_valid)
      else $error("result after an error");

endmodule

bind sse_event_stream_parser sse_checker u_sse_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ verif/sse_event_stream_parser_tb.sv @@
module sse_event_stream_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sse_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sse_pkg::rsp_type rsp_data;

   sse_event_stream_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   sse_pkg::req_type stream_items[$];
   sse_pkg::rsp_type due_outputs[$];
   sse_pkg::rsp_type step_rsps[$];
   logic             req_taken = 1'b0;
   int               items_in = 0;
   int               mismatches = 0;

   // Parser state as seen from outside
   logic [2:0]                     phase = sse_pkg::PH_START;
   logic [3:0]                     match_at = '0;
   logic                           value_start = 1'b0;
   logic                           cr_pending = 1'b0;
   logic                           lf_owed = 1'b0;
   logic                           data_open = 1'b0;
   logic [7:0]                     name_buf [sse_pkg::NAME_BYTES];
   logic [sse_pkg::NAME_LEN_W-1:0] name_len = '0;
   logic                           stopped = 1'b0;

   task automatic emit_rsp(input logic [2:0] kind, input logic [7:0] b,
                           input logic [1:0] code);
      sse_pkg::rsp_type r;
      r.kind       = kind;
      r.out_byte   = b;
      r.error_code = code;
      r.last       = 1'b0;
      step_rsps = {step_rsps, r};
   endtask

   task automatic stop_with(input logic [1:0] code);
      emit_rsp(sse_pkg::K_ERROR, 8'h00, code);
      stopped = 1'b1;
   endtask

   task automatic on_field_colon();
      if (!sse_pkg::WORD_END[match_at]) begin
         stop_with(sse_pkg::E_FIELD);
         return;
      end
      value_start = 1'b1;
      if (match_at == sse_pkg::FM_EVENT_END) begin
         name_len = '0;
         phase    = sse_pkg::PH_EVENT;
      end else if (match_at == sse_pkg::FM_DATA_END) begin
         if (lf_owed)
            emit_rsp(sse_pkg::K_DATA, sse_pkg::CHAR_LF, sse_pkg::E_COLON);
         lf_owed   = 1'b0;
         data_open = 1'b1;
         phase     = sse_pkg::PH_DATA;
      end else begin
         phase = sse_pkg::PH_SKIP;
      end
   endtask

   task automatic line_byte(input logic [7:0] b);
      logic       drop;
      logic [3:0] next_at;
      next_at = match_at + 4'd1;
      case (phase)
         sse_pkg::PH_START: begin
            if (b == sse_pkg::CHAR_COLON) begin
               phase = sse_pkg::PH_COMMENT;
            end else begin
               phase = sse_pkg::PH_FIELD;
               case (b)
                  sse_pkg::CHAR_E: match_at = sse_pkg::FM_EVENT;
                  sse_pkg::CHAR_D: match_at = sse_pkg::FM_DATA;
                  sse_pkg::CHAR_I: match_at = sse_pkg::FM_ID;
                  sse_pkg::CHAR_R: match_at = sse_pkg::FM_RETRY;
                  default:         phase = sse_pkg::PH_NOMATCH;
               endcase
            end
         end
         sse_pkg::PH_FIELD: begin
            if (b == sse_pkg::CHAR_COLON)
               on_field_colon();
            else if (!sse_pkg::WORD_END[match_at] && sse_pkg::FIELD_CHARS[next_at] == b)
               match_at = next_at;
            else
               phase = sse_pkg::PH_NOMATCH;
         end
         sse_pkg::PH_NOMATCH: begin
            if (b == sse_pkg::CHAR_COLON)
               stop_with(sse_pkg::E_FIELD);
         end
         sse_pkg::PH_DATA, sse_pkg::PH_EVENT: begin
            drop = value_start && b == sse_pkg::CHAR_SPACE;
            value_start = 1'b0;
            if (!drop) begin
               if (phase == sse_pkg::PH_DATA) begin
                  emit_rsp(sse_pkg::K_DATA, b, sse_pkg::E_COLON);
               end else if (name_len >= sse_pkg::NAME_BYTES) begin
                  stop_with(sse_pkg::E_OVERFLOW);
               end else begin
                  name_buf[name_len[sse_pkg::NAME_IDX_W-1:0]] = b;
                  name_len = name_len + 1'b1;
               end
            end
         end
         default: value_start = 1'b0;
      endcase
   endtask

   task automatic dispatch_event();
      if (!data_open && name_len == 0)
         return;
      for (int i = 0; i < name_len; i++)
         emit_rsp(sse_pkg::K_NAME, name_buf[i[sse_pkg::NAME_IDX_W-1:0]], sse_pkg::E_COLON);
      emit_rsp(sse_pkg::K_END, 8'h00, sse_pkg::E_COLON);
      data_open = 1'b0;
      lf_owed   = 1'b0;
      name_len  = '0;
   endtask

   task automatic close_line();
      if (phase == sse_pkg::PH_START) begin
         dispatch_event();
      end else if (phase == sse_pkg::PH_FIELD || phase == sse_pkg::PH_NOMATCH) begin
         stop_with(sse_pkg::E_COLON);
         return;
      end else if (phase == sse_pkg::PH_DATA) begin
         lf_owed = 1'b1;
      end
      phase       = sse_pkg::PH_START;
      match_at    = '0;
      value_start = 1'b0;
   endtask

   task automatic parse_item(input sse_pkg::req_type item);
      logic [7:0] b;
      b = item.byte_value;
      if (stopped)
         return;
      step_rsps.delete();
      if (item.command == sse_pkg::CMD_FINISH) begin
         if (cr_pending) begin
            cr_pending = 1'b0;
            line_byte(sse_pkg::CHAR_CR);
         end
         if (!stopped && phase != sse_pkg::PH_START)
            close_line();
         if (!stopped) begin
            if (data_open || name_len != 0)
               stop_with(sse_pkg::E_UNTERM);
            else
               emit_rsp(sse_pkg::K_DONE, 8'h00, sse_pkg::E_COLON);
         end
      end else if (cr_pending) begin
         cr_pending = 1'b0;
         if (b == sse_pkg::CHAR_LF) begin
            close_line();
         end else begin
            // a lone CR is an ordinary byte of the line
            line_byte(sse_pkg::CHAR_CR);
            if (!stopped) begin
               if (b == sse_pkg::CHAR_CR)
                  cr_pending = 1'b1;
               else
                  line_byte(b);
            end
         end
      end else if (b == sse_pkg::CHAR_LF) begin
         close_line();
      end else if (b == sse_pkg::CHAR_CR) begin
         cr_pending = 1'b1;
      end else begin
         line_byte(b);
      end
      if (step_rsps.size() != 0)
         step_rsps[step_rsps.size() - 1].last = 1'b1;
      foreach (step_rsps[i])
         due_outputs = {due_outputs, step_rsps[i]};
   endtask

   task automatic put_byte(input logic [7:0] b);
      sse_pkg::req_type item;
      item.command    = sse_pkg::CMD_BYTE;
      item.byte_value = b;
      stream_items = {stream_items, item};
   endtask

   task automatic put_finish();
      sse_pkg::req_type item;
      item.command    = sse_pkg::CMD_FINISH;
      item.byte_value = 8'($urandom_range(255));
      stream_items = {stream_items, item};
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         put_byte(s[i]);
   endtask

   task automatic put_line_end();
      if ($urandom_range(1) != 0)
         put_byte(sse_pkg::CHAR_CR);
      put_byte(sse_pkg::CHAR_LF);
   endtask

   task automatic put_opt_space();
      if ($urandom_range(1) != 0)
         put_byte(sse_pkg::CHAR_SPACE);
   endtask

   // Any byte but LF; CR now and then so lone CRs land inside values
   task automatic put_value(input int n);
      logic [7:0] b;
      repeat (n) begin
         if ($urandom_range(7) == 0) begin
            b = sse_pkg::CHAR_CR;
         end else begin
            do b = 8'($urandom_range(255));
            while (b == sse_pkg::CHAR_LF);
         end
         put_byte(b);
      end
   endtask

   task automatic put_event_block();
      int lines;
      lines = $urandom_range(1, 4);
      repeat (lines) begin
         case ($urandom_range(6))
            0, 1, 2: begin
               put_text("data:");
               put_opt_space();
               put_value($urandom_range(10));
            end
            3: begin
               put_text("event:");
               put_opt_space();
               put_value(($urandom_range(2) == 0) ? sse_pkg::NAME_BYTES
                                                  : $urandom_range(sse_pkg::NAME_BYTES));
            end
            4: begin
               put_text("id:");
               put_value($urandom_range(6));
            end
            5: begin
               put_text("retry:");
               put_value($urandom_range(6));
            end
            default: begin
               put_text(":");
               put_value($urandom_range(8));
            end
         endcase
         put_line_end();
      end
      put_line_end();
      // finish only on a clean boundary, sometimes inside an open comment
      if ($urandom_range(5) == 0) begin
         if ($urandom_range(1) != 0) begin
            put_text(":");
            put_value($urandom_range(4));
         end
         put_finish();
      end
   endtask

   function automatic logic idle_roll();
      logic quiet;
      quiet = items_in >= 80 && items_in < 160;
      return !quiet && ($urandom_range(99) < 27);
   endfunction

   task automatic note_mismatch(input logic have_want, input sse_pkg::rsp_type want,
                                input sse_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         if (have_want)
            $display("MISMATCH exp kind=%0d byte=%02h err=%0d last=%0d",
                     want.kind, want.out_byte, want.error_code, want.last);
         else
            $display("MISMATCH no result expected");
         $display("         got kind=%0d byte=%02h err=%0d last=%0d",
                  got.kind, got.out_byte, got.error_code, got.last);
      end
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (stream_items.size() != 0 && !idle_roll()) begin
               req_valid <= 1'b1;
               req_data  <= stream_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= idle_roll();
      end
   end

   always @(posedge clock) begin
      sse_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            parse_item(req_data);
            items_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_outputs.size() == 0) begin
               note_mismatch(1'b0, '0, rsp_data);
            end else begin
               want = due_outputs.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.out_byte !== want.out_byte ||
                   rsp_data.error_code !== want.error_code || rsp_data.last !== want.last)
                  note_mismatch(1'b1, want, rsp_data);
            end
         end
      end
   end

   initial begin
      // comment line ended by CRLF
      put_text(":c");
      put_byte(sse_pkg::CHAR_CR);
      put_byte(sse_pkg::CHAR_LF);
      // data with dropped space, byte extremes and a lone CR
      put_text("data: ");
      put_byte(8'h00);
      put_byte(sse_pkg::CHAR_CR);
      put_byte(8'hFF);
      put_byte(sse_pkg::CHAR_CR);
      put_byte(sse_pkg::CHAR_LF);
      // empty event name clears the name, then blank-line dispatch
      put_text("event:");
      put_byte(sse_pkg::CHAR_LF);
      put_byte(sse_pkg::CHAR_LF);
      // held CR at finish counts as an ordinary byte
      put_text("id:");
      put_byte(sse_pkg::CHAR_CR);
      put_finish();

      while (stream_items.size() < 220)
         put_event_block();

      // one terminal error, since the block halts until reset
      case ($urandom_range(4))
         0: begin
            put_byte(sse_pkg::CHAR_CR);
            put_finish();
         end
         1: begin
            put_text("data");
            put_byte(sse_pkg::CHAR_LF);
         end
         2: put_text(($urandom_range(1) != 0) ? "even:" : "x:");
         3: begin
            put_text("event:");
            repeat (sse_pkg::NAME_BYTES + 1)
               put_byte(8'($urandom_range(8'h61, 8'h7A)));
            put_byte(sse_pkg::CHAR_LF);
         end
         default: begin
            put_text("data:z");
            put_byte(sse_pkg::CHAR_LF);
            put_finish();
         end
      endcase
      // ignored after the halt
      put_text("data:q");
      put_byte(sse_pkg::CHAR_LF);
      put_finish();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stream_items.size() != 0 || req_valid)
         @(posedge clock);
      while (due_outputs.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0 && due_outputs.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
